>>> design/pngunf_pkg.sv
// Shared types and constants for the PNG scanline unfilter.
package pngunf_pkg;

	// Default size of the previous-line store in bytes.
	localparam int unsigned LINE_BYTES_DEF = 16384;

	localparam int unsigned PIX_W  = 13;
	localparam int unsigned ROWS_W = 16;
	localparam int unsigned CFG_W  = 16;
	localparam int unsigned IDX_W  = 2;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_ROW_PIXELS = 2'd0;
	localparam logic [IDX_W-1:0] REG_ROW_TOTAL  = 2'd1;
	localparam logic [IDX_W-1:0] REG_ALPHA_MODE = 2'd2;

	// Highest legal filter type code.
	localparam logic [7:0] MAX_FILTER = 8'd4;

	typedef enum logic [2:0] {
		FLT_NONE  = 3'd0,
		FLT_SUB   = 3'd1,
		FLT_UP    = 3'd2,
		FLT_AVG   = 3'd3,
		FLT_PAETH = 3'd4
	} filter_t;

	// The three neighbors of the byte being rebuilt.
	typedef struct packed {
		logic [7:0] left;
		logic [7:0] up;
		logic [7:0] up_left;
	} nbr_t;

endpackage

>>> design/png_scanline_unfilter.sv
// PNG scanline unfilter: rebuilds 8-bit RGB or RGBA rows from a filtered byte stream.
// The result of an accepted data byte is registered in the first stage and then in the output register.
// Throughput: one byte per cycle while the input is not stalled; the line store has one read and one write port.
// A held result stalls the input only once the stage ahead of the output is also full.
// Reset clears all control state; the line store itself has no reset and no clearing pass.
module png_scanline_unfilter #(
	parameter int unsigned MAX_LINE_BYTES = pngunf_pkg::LINE_BYTES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// Configuration write port.
	input  logic                         cfg_we,
	input  logic [pngunf_pkg::IDX_W-1:0] cfg_index,
	input  logic [pngunf_pkg::CFG_W-1:0] cfg_data,
	// Filtered byte requests.
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [7:0]                   in_byte,
	// Reconstructed byte requests.
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [7:0]                   pixel_byte,
	output logic                         row_end,
	output logic                         image_end,
	output logic                         bad_filter
);
	import pngunf_pkg::*;

	// Address width of the line store, width of a byte count within a line
	// (which must hold the full line length), and a compare width wide
	// enough for both that count and the raw width-times-bpp product.
	localparam int unsigned AW   = $clog2(MAX_LINE_BYTES);
	localparam int unsigned LBW  = $clog2(MAX_LINE_BYTES + 1);
	localparam int unsigned PRW  = 15;
	localparam int unsigned CW   = (LBW > PRW) ? LBW : PRW;

	// Configuration registers.
	logic [PIX_W-1:0]  row_pixels_q;
	logic [ROWS_W-1:0] row_total_q;
	logic              alpha_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_pixels_q <= PIX_W'(1);
			row_total_q  <= ROWS_W'(1);
			alpha_mode_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROW_PIXELS: row_pixels_q <= cfg_data[PIX_W-1:0];
				REG_ROW_TOTAL:  row_total_q  <= cfg_data[ROWS_W-1:0];
				REG_ALPHA_MODE: alpha_mode_q <= cfg_data[0];
				default:        ;
			endcase
		end
	end

	// Line length in bytes. A zero width counts as one pixel, and the
	// product is capped at the size of the line store. Three bytes per
	// pixel is an add of the width and twice the width.
	logic [PIX_W-1:0]  px_eff;
	logic [PRW-1:0]    line_prod;
	logic [LBW-1:0]    line_len;
	logic [LBW-1:0]    line_last;
	logic [ROWS_W:0]   rows_eff;
	logic [2:0]        bpp;

	always_comb begin
		px_eff    = (row_pixels_q == '0) ? PIX_W'(1) : row_pixels_q;
		line_prod = alpha_mode_q ? {px_eff, 2'b00}
		                         : ({2'b00, px_eff} + {1'b0, px_eff, 1'b0});
		line_len  = (CW'(line_prod) > CW'(MAX_LINE_BYTES)) ? LBW'(MAX_LINE_BYTES)
		                                                   : LBW'(line_prod);
		line_last = line_len - LBW'(1);
		rows_eff  = (row_total_q == '0) ? (ROWS_W+1)'(1) : {1'b0, row_total_q};
		bpp       = alpha_mode_q ? 3'd4 : 3'd3;
	end

	// Row and image position. A byte column of zero means the next byte is
	// a filter type; otherwise it is one more than the data column.
	logic [LBW-1:0]    byte_col_q;
	logic [ROWS_W-1:0] row_index_q;
	logic              first_row_q;
	logic              halted_q;
	filter_t           filter_kind_q;

	// First pipeline stage: the accepted byte and its position, while the
	// line store read for the byte above is in flight.
	logic              valid_s1;
	logic              err_s1;
	logic [7:0]        byte_s1;
	logic [AW-1:0]     col_s1;
	filter_t           kind_s1;
	logic              first_s1;
	logic              has_left_s1;
	logic              alpha_s1;
	logic              rend_s1;
	logic              iend_s1;

	// Output register.
	logic              out_valid_q;
	logic [7:0]        pixel_byte_q;
	logic              row_end_q;
	logic              image_end_q;
	logic              bad_filter_q;

	// The first stage moves into the output register whenever the output
	// register is empty or is being taken in this cycle. A new byte is
	// taken whenever the first stage is empty or moving on, so a waiting
	// result does not hold up the input by more than the one stage.
	logic s1_adv;
	logic in_acc;

	assign s1_adv   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign in_acc   = in_valid && !in_stall;

	// Classification of the incoming byte.
	logic           is_filter;
	logic           is_bad;
	logic           is_data;
	logic [LBW-1:0] col_raw;
	logic [LBW-1:0] col_full;
	logic [AW-1:0]  col;
	logic           rend;
	logic           iend;
	logic [ROWS_W:0] row_next;

	always_comb begin
		is_filter = !halted_q && (byte_col_q == '0);
		is_bad    = is_filter && (in_byte > MAX_FILTER);
		is_data   = !halted_q && (byte_col_q != '0);
		col_raw   = byte_col_q - LBW'(1);
		// A line that shrank under a running row ends on its new last byte.
		col_full  = (col_raw > line_last) ? line_last : col_raw;
		col       = col_full[AW-1:0];
		rend      = (col_full == line_last);
		row_next  = {1'b0, row_index_q} + (ROWS_W+1)'(1);
		iend      = rend && (row_next >= rows_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_col_q    <= '0;
			row_index_q   <= '0;
			first_row_q   <= 1'b1;
			halted_q      <= 1'b0;
			filter_kind_q <= FLT_NONE;
		end else if (in_acc) begin
			if (is_bad) begin
				halted_q <= 1'b1;
			end else if (is_filter) begin
				filter_kind_q <= filter_t'(in_byte[2:0]);
				byte_col_q    <= LBW'(1);
			end else if (is_data) begin
				if (rend) begin
					byte_col_q <= '0;
					if (iend) begin
						row_index_q <= '0;
						first_row_q <= 1'b1;
					end else begin
						row_index_q <= row_next[ROWS_W-1:0];
						first_row_q <= 1'b0;
					end
				end else begin
					byte_col_q <= LBW'(col_full + LBW'(2));
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc && (is_data || is_bad)) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && (is_data || is_bad)) begin
			err_s1      <= is_bad;
			byte_s1     <= in_byte;
			col_s1      <= col;
			kind_s1     <= filter_kind_q;
			first_s1    <= first_row_q;
			has_left_s1 <= CW'(col_full) >= CW'(bpp);
			alpha_s1    <= alpha_mode_q;
			rend_s1     <= rend;
			iend_s1     <= iend;
		end
	end

	// Line store: the read for a data byte goes out at its accept edge;
	// the rebuilt byte is written back when the byte leaves the first stage.
	logic       rd_en;
	logic       wr_en;
	logic [7:0] ram_rd;
	logic [7:0] recon;

	assign rd_en = in_acc && is_data;
	assign wr_en = s1_adv && !err_s1;

	pngunf_line_ram #(
		.DEPTH (MAX_LINE_BYTES),
		.AW    (AW)
	) u_line_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (col_s1),
		.wr_data (recon),
		.rd_en   (rd_en),
		.rd_addr (col),
		.rd_data (ram_rd)
	);

	// When a read and a write meet at the same entry in one cycle, the
	// store returns the old byte, so the written byte is kept aside and
	// used in its place.
	logic       fwd_hit_q;
	logic [7:0] fwd_byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_q <= 1'b0;
		end else if (rd_en) begin
			fwd_hit_q <= wr_en && (col_s1 == col);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			fwd_byte_q <= recon;
		end
	end

	// Left and above-left history, newest first. The entry one pixel back
	// sits at index two for RGB and three for RGBA.
	logic [7:0] left_hist_q [4];
	logic [7:0] up_left_hist_q [4];
	logic [7:0] up_byte;
	nbr_t       nbr;

	always_comb begin
		up_byte     = first_s1 ? 8'd0 : (fwd_hit_q ? fwd_byte_q : ram_rd);
		nbr.up      = up_byte;
		nbr.left    = !has_left_s1 ? 8'd0
		            : (alpha_s1 ? left_hist_q[3] : left_hist_q[2]);
		nbr.up_left = (!has_left_s1 || first_s1) ? 8'd0
		            : (alpha_s1 ? up_left_hist_q[3] : up_left_hist_q[2]);
	end

	pngunf_predict u_predict (
		.kind  (kind_s1),
		.nbr   (nbr),
		.raw   (byte_s1),
		.recon (recon)
	);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			left_hist_q[3]    <= left_hist_q[2];
			left_hist_q[2]    <= left_hist_q[1];
			left_hist_q[1]    <= left_hist_q[0];
			left_hist_q[0]    <= recon;
			up_left_hist_q[3] <= up_left_hist_q[2];
			up_left_hist_q[2] <= up_left_hist_q[1];
			up_left_hist_q[1] <= up_left_hist_q[0];
			up_left_hist_q[0] <= up_byte;
		end
	end

	// Output register. The error result carries a zero byte and no marks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			pixel_byte_q <= err_s1 ? 8'd0 : recon;
			row_end_q    <= !err_s1 && rend_s1;
			image_end_q  <= !err_s1 && iend_s1;
			bad_filter_q <= err_s1;
		end
	end

	assign out_valid  = out_valid_q;
	assign pixel_byte = pixel_byte_q;
	assign row_end    = row_end_q;
	assign image_end  = image_end_q;
	assign bad_filter = bad_filter_q;

	// An image always closes on the last byte of a row.
	a_image_end_on_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && image_end |-> row_end)
		else $error("image end without row end");

	// Once a bad filter type is seen, the block stays halted until reset.
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halt released without reset");

	// An error result can only exist after the halt has been raised.
	a_error_halted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_filter |-> halted_q)
		else $error("error result while not halted");

	// The stage ahead of the output never stalls the input while it is empty.
	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q)
		else $error("input stalled with an empty pipeline");

endmodule

>>> design/pngunf_line_ram.sv
// Previous-line store: one write port, one read port, registered read data.
module pngunf_line_ram #(
	parameter int unsigned DEPTH = pngunf_pkg::LINE_BYTES_DEF,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem_q [DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// A read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> design/pngunf_predict.sv
// Predictor and byte reconstruction for the five PNG filter types.
module pngunf_predict (
	input  pngunf_pkg::filter_t kind,
	input  pngunf_pkg::nbr_t    nbr,
	input  logic [7:0]          raw,
	output logic [7:0]          recon
);
	import pngunf_pkg::*;

	logic signed [9:0] sa, sb, sc;
	logic signed [9:0] da, db, dc;
	logic [9:0]        pa, pb, pc;
	logic [8:0]        avg_sum;
	logic [7:0]        paeth;
	logic [7:0]        pred;

	function automatic logic [9:0] abs10(input logic signed [9:0] v);
		abs10 = v[9] ? 10'(-v) : 10'(v);
	endfunction

	always_comb begin
		sa = $signed({2'b00, nbr.left});
		sb = $signed({2'b00, nbr.up});
		sc = $signed({2'b00, nbr.up_left});
		// With p = a + b - c the three distances reduce to these forms.
		da = sb - sc;
		db = sa - sc;
		dc = sa + sb - (sc <<< 1);
		pa = abs10(da);
		pb = abs10(db);
		pc = abs10(dc);
		if (pa <= pb && pa <= pc) begin
			paeth = nbr.left;
		end else if (pb <= pc) begin
			paeth = nbr.up;
		end else begin
			paeth = nbr.up_left;
		end
		avg_sum = {1'b0, nbr.left} + {1'b0, nbr.up};
		case (kind)
			FLT_NONE:  pred = 8'd0;
			FLT_SUB:   pred = nbr.left;
			FLT_UP:    pred = nbr.up;
			FLT_AVG:   pred = avg_sum[8:1];
			FLT_PAETH: pred = paeth;
			default:   pred = 8'd0;
		endcase
		recon = raw + pred;
	end

endmodule
